[rtl/pcm_pkg.sv]
// Package for the PWM capture measurement unit.
// Holds the fixed field widths, constants and the result record shared by all files but the queue.
// Depends on nothing.
`default_nettype none

package pcm_pkg;

	localparam int TIME_W     = 16;
	localparam int TICK_W     = 27;
	localparam int DUTY_W     = 7;
	localparam int DUTY_SCALE = 100;
	localparam int DUTY_MAX   = 100;
	localparam int DIV_CNT_W  = $clog2(TICK_W + 1);

	localparam logic [TICK_W-1:0] TICK_HZ_RESET = 27'd1000000;

	typedef struct packed {
		logic [TIME_W-1:0] high_ticks;
		logic [TIME_W-1:0] low_ticks;
		logic [TIME_W-1:0] period_ticks;
		logic [DUTY_W-1:0] duty_percent;
		logic [TICK_W-1:0] frequency_hz;
		logic              period_zero;
	} pcm_result_t;

endpackage

`default_nettype wire

[rtl/pcm_front.sv]
// Front end of the PWM capture measurement unit: accepts edge items and tracks the phase.
// Pushes high and low tick counts of each completed period into the job queue.
// Depends on pcm_pkg.
`default_nettype none

module pcm_front #(
	parameter int CNT_W = 16
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire [pcm_pkg::TIME_W-1:0]     capture_time,
	input  wire                           edge_rising,
	output logic                          push_valid,
	input  wire                           push_ready,
	output logic [2*CNT_W-1:0]            push_data
);
	import pcm_pkg::*;

	localparam logic [1:0] PH_RISE  = 2'd0;
	localparam logic [1:0] PH_FALL  = 2'd1;
	localparam logic [1:0] PH_CLOSE = 2'd2;

	logic [1:0]       phase_q;
	logic [CNT_W-1:0] rise_q;
	logic [CNT_W-1:0] fall_q;
	logic [CNT_W-1:0] t_now;
	logic [CNT_W-1:0] hi_ticks;
	logic [CNT_W-1:0] lo_ticks;
	logic             accept;

	assign in_ready   = push_ready;
	assign accept     = in_valid && in_ready;
	assign t_now      = CNT_W'(capture_time);
	assign hi_ticks   = fall_q - rise_q;
	assign lo_ticks   = t_now - fall_q;
	assign push_valid = accept && (phase_q == PH_CLOSE) && edge_rising;
	assign push_data  = {hi_ticks, lo_ticks};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RISE;
		end else if (accept) begin
			case (phase_q)
				PH_FALL: begin
					if (!edge_rising) begin
						phase_q <= PH_CLOSE;
					end
				end
				PH_CLOSE: begin
					if (edge_rising) begin
						phase_q <= PH_FALL;
					end
				end
				default: begin
					if (edge_rising) begin
						phase_q <= PH_FALL;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (phase_q == PH_FALL) begin
				if (!edge_rising) begin
					fall_q <= t_now;
				end
			end else if (edge_rising) begin
				rise_q <= t_now;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/pcm_queue.sv]
// Two-entry job queue between the front end and the arithmetic back end.
// Depends on nothing beyond its width parameter.
`default_nettype none

module pcm_queue #(
	parameter int DATA_W = 32
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push_valid,
	output logic              push_ready,
	input  wire [DATA_W-1:0]  push_data,
	output logic              pop_valid,
	input  wire               pop_ready,
	output logic [DATA_W-1:0] pop_data
);
	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

[rtl/pcm_back.sv]
// Back end of the PWM capture measurement unit: period, duty and frequency arithmetic.
// Uses one shared restoring divider and holds the result in an output register.
// Depends on pcm_pkg.
`default_nettype none

module pcm_back #(
	parameter int CNT_W = 16
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        job_valid,
	output logic                       job_ready,
	input  wire [2*CNT_W-1:0]          job_data,
	input  wire [pcm_pkg::TICK_W-1:0]  tick_hz,
	output logic                       out_valid,
	input  wire                        out_ready,
	output pcm_pkg::pcm_result_t       result
);
	import pcm_pkg::*;

	localparam int PROD_W = CNT_W + DUTY_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_DUTY = 3'd2;
	localparam logic [2:0] ST_FREQ = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]           state_q;
	logic [CNT_W-1:0]     hi_q;
	logic [CNT_W-1:0]     lo_q;
	logic [CNT_W-1:0]     per_q;
	logic [CNT_W-1:0]     rem_q;
	logic [TICK_W-1:0]    sh_q;
	logic [TICK_W-1:0]    quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DUTY_W-1:0]    duty_q;
	logic                 zero_q;
	logic                 out_valid_q;
	pcm_result_t          res_q;

	logic [PROD_W-1:0]    prod;
	logic [CNT_W:0]       rem_sh;
	logic [CNT_W:0]       diff;
	logic                 ge;
	logic [CNT_W-1:0]     rem_next;
	logic [TICK_W-1:0]    quo_next;
	logic                 last_step;
	logic                 emit_fire;

	assign job_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign result    = res_q;
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign last_step = (cnt_q == DIV_CNT_W'(1));

	always_comb begin
		prod     = PROD_W'(hi_q) * PROD_W'(DUTY_SCALE);
		rem_sh   = {rem_q, sh_q[TICK_W-1]};
		diff     = rem_sh - {1'b0, per_q};
		ge       = (rem_sh >= {1'b0, per_q});
		rem_next = ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
		quo_next = {quo_q[TICK_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (per_q == '0) begin
						state_q <= ST_EMIT;
					end else if (hi_q >= per_q) begin
						state_q <= ST_FREQ;
						cnt_q   <= DIV_CNT_W'(TICK_W);
					end else begin
						state_q <= ST_DUTY;
						cnt_q   <= DIV_CNT_W'(DUTY_W);
					end
				end
				ST_DUTY: begin
					if (last_step) begin
						state_q <= ST_FREQ;
						cnt_q   <= DIV_CNT_W'(TICK_W);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_FREQ: begin
					if (last_step) begin
						state_q <= ST_EMIT;
					end
					cnt_q <= cnt_q - 1'b1;
				end
				ST_EMIT: begin
					if (emit_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				hi_q  <= job_data[2*CNT_W-1:CNT_W];
				lo_q  <= job_data[CNT_W-1:0];
				per_q <= job_data[2*CNT_W-1:CNT_W] + job_data[CNT_W-1:0];
			end
			ST_PREP: begin
				zero_q <= (per_q == '0);
				quo_q  <= '0;
				if (per_q == '0) begin
					duty_q <= '0;
				end else if (hi_q >= per_q) begin
					duty_q <= DUTY_W'(DUTY_MAX);
					rem_q  <= '0;
					sh_q   <= tick_hz;
				end else begin
					rem_q <= prod[PROD_W-1:DUTY_W];
					sh_q  <= {prod[DUTY_W-1:0], (TICK_W - DUTY_W)'(0)};
				end
			end
			ST_DUTY: begin
				if (last_step) begin
					duty_q <= quo_next[DUTY_W-1:0];
					quo_q  <= '0;
					rem_q  <= '0;
					sh_q   <= tick_hz;
				end else begin
					quo_q <= quo_next;
					rem_q <= rem_next;
					sh_q  <= {sh_q[TICK_W-2:0], 1'b0};
				end
			end
			ST_FREQ: begin
				quo_q <= quo_next;
				rem_q <= rem_next;
				sh_q  <= {sh_q[TICK_W-2:0], 1'b0};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			res_q.high_ticks   <= TIME_W'(hi_q);
			res_q.low_ticks    <= TIME_W'(lo_q);
			res_q.period_ticks <= TIME_W'(per_q);
			res_q.duty_percent <= duty_q;
			res_q.frequency_hz <= quo_q;
			res_q.period_zero  <= zero_q;
		end
	end

endmodule

`default_nettype wire

[rtl/pwm_capture_measure_unit.sv]
// PWM capture measurement unit, top level.
// Measures high time, low time, period, duty and frequency from timestamped capture edges.
// Depends on pcm_pkg, pcm_front, pcm_queue and pcm_back.
//
// Usage:
// Edge items (capture_time, edge_rising) enter on the in_valid/in_ready channel. The unit
// waits for a rising edge, then a falling edge, then a closing rising edge; the closing
// edge yields one result and also opens the next measurement. Edges of the wrong polarity
// are dropped without a result.
// Results leave on the out_valid/out_ready channel from an output register.
// An edge item is taken while the job queue has room. A closing edge gives its result after
// the duty and frequency divisions, the frequency one alone when the duty saturates, or none
// for a zero period; the back end takes no job meanwhile. The shared bit-serial divider runs
// seven steps for the duty and 27 for the frequency. A stalled receiver holds the result in
// the output register; the back end then holds its finished job and the two-entry queue
// fills, after which in_ready falls. The tick rate register is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while the unit is idle, as the unit never checks.
// Reset clears the phase, the queue and the output valid, and loads a tick rate of 1 MHz.
`default_nettype none

module pwm_capture_measure_unit #(
	parameter int COUNTER_WIDTH = 16
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_wr_en,
	input  wire [pcm_pkg::TICK_W-1:0]  cfg_wr_data,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire [pcm_pkg::TIME_W-1:0]  capture_time,
	input  wire                        edge_rising,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic [pcm_pkg::TIME_W-1:0] high_ticks,
	output logic [pcm_pkg::TIME_W-1:0] low_ticks,
	output logic [pcm_pkg::TIME_W-1:0] period_ticks,
	output logic [pcm_pkg::DUTY_W-1:0] duty_percent,
	output logic [pcm_pkg::TICK_W-1:0] frequency_hz,
	output logic                       period_zero
);
	import pcm_pkg::*;

	logic [TICK_W-1:0]          tick_hz_q;
	logic                       push_valid;
	logic                       push_ready;
	logic [2*COUNTER_WIDTH-1:0] push_data;
	logic                       job_valid;
	logic                       job_ready;
	logic [2*COUNTER_WIDTH-1:0] job_data;
	pcm_result_t                result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_hz_q <= TICK_HZ_RESET;
		end else if (cfg_wr_en) begin
			tick_hz_q <= cfg_wr_data;
		end
	end

	pcm_front #(
		.CNT_W(COUNTER_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.capture_time(capture_time),
		.edge_rising (edge_rising),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	pcm_queue #(
		.DATA_W(2 * COUNTER_WIDTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (job_valid),
		.pop_ready (job_ready),
		.pop_data  (job_data)
	);

	pcm_back #(
		.CNT_W(COUNTER_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job_data (job_data),
		.tick_hz  (tick_hz_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result   (result)
	);

	assign high_ticks   = result.high_ticks;
	assign low_ticks    = result.low_ticks;
	assign period_ticks = result.period_ticks;
	assign duty_percent = result.duty_percent;
	assign frequency_hz = result.frequency_hz;
	assign period_zero  = result.period_zero;

`ifndef NO_ASSERTIONS
	a_zero_forces_quotients: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && period_zero |-> duty_percent == '0 && frequency_hz == '0)
		else $error("zero period result carries non-zero duty or frequency");

	a_duty_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> duty_percent <= DUTY_W'(DUTY_MAX))
		else $error("duty above full scale");

	a_back_busy_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && job_ready |=> !job_ready)
		else $error("back end took a second job while busy");
`endif

endmodule

`default_nettype wire
